// ===== sv/atl_pkg.sv =====
package atl_pkg;

    typedef enum logic [3:0] {
        KIND_ADD    = 4'd0,
        KIND_SUB    = 4'd1,
        KIND_MULT   = 4'd2,
        KIND_DIV    = 4'd3,
        KIND_SEMI   = 4'd4,
        KIND_LPAREN = 4'd5,
        KIND_RPAREN = 4'd6,
        KIND_LBRACE = 4'd7,
        KIND_RBRACE = 4'd8,
        KIND_NUMBER = 4'd9,
        KIND_LETTER = 4'd10,
        KIND_IDEND  = 4'd11,
        KIND_END    = 4'd12,
        KIND_ERROR  = 4'd13
    } t_kind;

    localparam logic [7:0] CH_EOT     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;

    localparam int VALUE_W = 32;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  number_value;
        logic [7:0]          letter;
        logic                last_of_run;
    } t_result;

    typedef struct packed {
        t_result     res0;
        t_result     res1;
        logic [1:0]  cnt;
    } t_step_out;

    typedef struct packed {
        logic   hit;
        t_kind  kind;
    } t_op;

    function automatic t_op op_lookup(input logic [7:0] ch);
        t_op r;
        r.hit  = 1'b1;
        r.kind = KIND_ADD;
        case (ch)
            CH_PLUS:   r.kind = KIND_ADD;
            CH_MINUS:  r.kind = KIND_SUB;
            CH_STAR:   r.kind = KIND_MULT;
            CH_SLASH:  r.kind = KIND_DIV;
            CH_SEMI:   r.kind = KIND_SEMI;
            CH_LPAREN: r.kind = KIND_LPAREN;
            CH_RPAREN: r.kind = KIND_RPAREN;
            CH_LBRACE: r.kind = KIND_LBRACE;
            CH_RBRACE: r.kind = KIND_RBRACE;
            default:   r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/atl_core.sv =====
module atl_core #(
    parameter int NUMBER_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_ch,
    output atl_pkg::t_step_out o_out
);
    import atl_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic [NUMBER_BITS-1:0] r_acc, n_acc;
    logic                   r_halt, n_halt;

    logic                   is_digit;
    logic                   is_letter;
    logic [3:0]             digit;
    t_op                    op;
    t_result                res [2];
    logic [1:0]             cnt;
    logic                   done;

    assign is_digit  = i_ch inside {[CH_ZERO:CH_NINE]};
    assign is_letter = i_ch inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    assign digit     = 4'(i_ch - CH_ZERO);
    assign op        = op_lookup(i_ch);

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_halt = r_halt;
        res[0] = '0;
        res[1] = '0;
        cnt    = 2'd0;
        done   = 1'b0;
        if (!r_halt) begin
            case (r_mode)
                MODE_NUM: begin
                    if (is_digit) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + NUMBER_BITS'(digit);
                        done  = 1'b1;
                    end else begin
                        res[0].kind         = KIND_NUMBER;
                        res[0].number_value = VALUE_W'(r_acc);
                        cnt    = 2'd1;
                        n_acc  = '0;
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_IDENT: begin
                    if (is_letter) begin
                        res[0].kind   = KIND_LETTER;
                        res[0].letter = i_ch;
                        cnt  = 2'd1;
                        done = 1'b1;
                    end else begin
                        res[0].kind = KIND_IDEND;
                        cnt    = 2'd1;
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
            if (!done) begin
                if (op.hit) begin
                    res[cnt[0]].kind = op.kind;
                    cnt = cnt + 2'd1;
                end else if (i_ch == CH_EOT) begin
                    res[cnt[0]].kind = KIND_END;
                    cnt = cnt + 2'd1;
                end else if (i_ch == CH_SPACE || i_ch == CH_NEWLINE) begin
                    n_mode = MODE_IDLE;
                end else if (is_digit) begin
                    n_mode = MODE_NUM;
                    n_acc  = NUMBER_BITS'(digit);
                end else if (is_letter) begin
                    n_mode = MODE_IDENT;
                    res[cnt[0]].kind   = KIND_LETTER;
                    res[cnt[0]].letter = i_ch;
                    cnt = cnt + 2'd1;
                end else begin
                    res[cnt[0]].kind = KIND_ERROR;
                    cnt    = cnt + 2'd1;
                    n_halt = 1'b1;
                end
            end
            if (cnt == 2'd1) begin
                res[0].last_of_run = 1'b1;
            end else if (cnt == 2'd2) begin
                res[1].last_of_run = 1'b1;
            end
        end
    end

    assign o_out.res0 = res[0];
    assign o_out.res1 = res[1];
    assign o_out.cnt  = i_step ? cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_halt <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_halt <= n_halt;
        end
    end

endmodule

// ===== sv/atl_fifo.sv =====
module atl_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  atl_pkg::t_step_out i_push,
    output logic               o_room2,
    output logic               o_valid,
    input  logic               i_pop,
    output atl_pkg::t_result   o_data
);
    import atl_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_result            mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]     r_count, n_count;
    logic               pop_ok;
    logic [PTR_W-1:0]   wr_ptr1;

    assign pop_ok  = i_pop && (r_count != '0);
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);
    assign n_wr_ptr = r_wr_ptr + PTR_W'(i_push.cnt);
    assign n_rd_ptr = r_rd_ptr + PTR_W'(pop_ok);
    assign n_count  = r_count + (PTR_W+1)'(i_push.cnt) - (PTR_W+1)'(pop_ok);

    assign o_room2 = r_count <= (PTR_W+1)'(DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            mem[wr_ptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== sv/arith_token_lexer.sv =====
// arith_token_lexer: turns a stream of source bytes into arithmetic tokens
// slave side: one byte per request in s_axis_tdata, byte zero ends a text
// master side: one token per request; tuser carries the token kind, tdata
// carries the number value and the identifier letter, tlast marks the
// final token caused by one input byte
// a byte is taken into an input register, decoded against the lexer state
// once the queue has room for two tokens, and its zero, one or two tokens
// are written to a four-entry result queue, from which the master side reads
// throughput is one byte per cycle while each byte gives at most one token
// and the receiver does not stall; a byte that ends a number or identifier
// and also gives a token of its own writes two tokens to the queue at once,
// while the master side reads at most one token per cycle
// when the receiver stalls the queue fills and tready drops once fewer
// than two entries are free; nothing is lost or repeated
// after an error token all input is taken and dropped until reset
// reset (synchronous, active low) empties the queue and returns to idle
module arith_token_lexer #(
    parameter int NUMBER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // number_value[31:0], letter[39:32]
    output logic [3:0]  m_axis_tuser,   // kind[3:0]
    output logic        m_axis_tlast
);
    import atl_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       room2;
    logic       step;
    t_step_out  step_out;
    t_result    head;

    assign step          = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_ch <= s_axis_tdata;
        end
    end

    atl_core #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ch    (r_ch),
        .o_out   (step_out)
    );

    atl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step_out),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_data  (head)
    );

    assign m_axis_tdata = {head.letter, head.number_value};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_run;

endmodule
